### rtl/bmiw_pkg.sv
package bmiw_pkg;

    // Fixed field widths of the item and result ports.
    localparam int CMD_BITS   = 2;
    localparam int SLOT_BITS  = 4;
    localparam int IDX_BITS   = 32;
    localparam int WORD_BITS  = 14;
    localparam int KIND_BITS  = 2;
    localparam int LOG2_BITS  = 4;
    localparam int LEVEL_BITS = 2;

    // Width used to compare a logical index against the triple-level limit.
    localparam int BOUND_BITS = 44;

    // Defaults for the top-level parameters.
    localparam int DIRECT_SLOTS_DEF      = 12;
    localparam int BLOCK_NUMBER_BITS_DEF = 32;

    // Inode pointer table layout.
    localparam int TABLE_DEPTH = 15;
    localparam logic [SLOT_BITS-1:0] SLOT_SINGLE = 4'd12;
    localparam logic [SLOT_BITS-1:0] SLOT_DOUBLE = 4'd13;
    localparam logic [SLOT_BITS-1:0] SLOT_TRIPLE = 4'd14;
    localparam logic [SLOT_BITS-1:0] SLOT_LAST   = 4'd14;

    // Legal range of pointers_per_block_log2.
    localparam logic [LOG2_BITS-1:0] LOG2_MIN = 4'd8;
    localparam logic [LOG2_BITS-1:0] LOG2_MAX = 4'd14;
    localparam logic [LOG2_BITS-1:0] LOG2_RESET = 4'd8;

    // Command codes.
    localparam logic [CMD_BITS-1:0] CMD_LOAD     = 2'd0;
    localparam logic [CMD_BITS-1:0] CMD_RESOLVE  = 2'd1;
    localparam logic [CMD_BITS-1:0] CMD_RESPONSE = 2'd2;

    // Result kinds.
    localparam logic [KIND_BITS-1:0] KIND_REQUEST  = 2'd0;
    localparam logic [KIND_BITS-1:0] KIND_RESOLVED = 2'd1;
    localparam logic [KIND_BITS-1:0] KIND_ERROR    = 2'd2;

    // Walk depth counts.
    localparam logic [LEVEL_BITS-1:0] LEVELS_ONE   = 2'd1;
    localparam logic [LEVEL_BITS-1:0] LEVELS_TWO   = 2'd2;
    localparam logic [LEVEL_BITS-1:0] LEVELS_THREE = 2'd3;

    // Which part of the index space a logical index falls into.
    typedef enum logic [2:0] {
        LVL_DIRECT,
        LVL_SINGLE,
        LVL_DOUBLE,
        LVL_TRIPLE,
        LVL_RANGE
    } level_t;

    // Controller states.
    typedef enum logic {
        ST_IDLE,
        ST_EVAL
    } state_t;

    // Classification of an incoming logical index.
    typedef struct packed {
        level_t                level;
        logic [SLOT_BITS-1:0]  slot;
        logic [IDX_BITS-1:0]   base_single;
        logic [IDX_BITS-1:0]   base_double;
        logic [IDX_BITS-1:0]   base_triple;
    } decode_t;

endpackage

### rtl/bmiw_ptr_mem.sv
module bmiw_ptr_mem #(
    parameter int BLOCK_NUMBER_BITS = bmiw_pkg::BLOCK_NUMBER_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               wr_en,
    input  logic [bmiw_pkg::SLOT_BITS-1:0]     wr_addr,
    input  logic [BLOCK_NUMBER_BITS-1:0]       wr_data,
    input  logic [bmiw_pkg::SLOT_BITS-1:0]     rd_addr,
    output logic [BLOCK_NUMBER_BITS-1:0]       rd_data
);
    import bmiw_pkg::*;

    logic [BLOCK_NUMBER_BITS-1:0] mem [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0]       valid_reg;
    logic [BLOCK_NUMBER_BITS-1:0] rd_data_reg;
    logic                         rd_valid_reg;

    // Pointer storage; written by load items.
    always_ff @(posedge clk)
    begin
        if (wr_en && (wr_addr <= SLOT_LAST))
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[(rd_addr <= SLOT_LAST) ? rd_addr : SLOT_LAST];
    end

    // Valid bits make every never-written slot read as a hole right after reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en && (wr_addr <= SLOT_LAST))
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            rd_valid_reg <= (rd_addr <= SLOT_LAST) && valid_reg[rd_addr];
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

### rtl/bmiw_index_decode.sv
module bmiw_index_decode #(
    parameter int DIRECT_SLOTS = bmiw_pkg::DIRECT_SLOTS_DEF
) (
    input  logic [bmiw_pkg::IDX_BITS-1:0]  logical_index,
    input  logic [bmiw_pkg::LOG2_BITS-1:0] log2_ppb,
    output bmiw_pkg::decode_t              dec
);
    import bmiw_pkg::*;

    logic [4:0]            shift2;
    logic [5:0]            shift3;
    logic [BOUND_BITS-1:0] idx_wide;
    logic [BOUND_BITS-1:0] bound_direct;
    logic [BOUND_BITS-1:0] bound_single;
    logic [BOUND_BITS-1:0] bound_double;
    logic [BOUND_BITS-1:0] bound_triple;

    // Region limits depend only on DIRECT_SLOTS and the configured block size.
    assign shift2       = {1'b0, log2_ppb} << 1;
    assign shift3       = {1'b0, shift2} + {2'b00, log2_ppb};
    assign idx_wide     = {{(BOUND_BITS-IDX_BITS){1'b0}}, logical_index};
    assign bound_direct = BOUND_BITS'(DIRECT_SLOTS);
    assign bound_single = bound_direct + (BOUND_BITS'(1) << log2_ppb);
    assign bound_double = bound_single + (BOUND_BITS'(1) << shift2);
    assign bound_triple = bound_double + (BOUND_BITS'(1) << shift3);

    // Classify the index and pick the inode slot to read.
    always_comb
    begin
        dec.base_single = bound_direct[IDX_BITS-1:0];
        dec.base_double = bound_single[IDX_BITS-1:0];
        dec.base_triple = bound_double[IDX_BITS-1:0];
        if (idx_wide < bound_direct)
        begin
            dec.level = LVL_DIRECT;
            dec.slot  = logical_index[SLOT_BITS-1:0];
        end
        else if (idx_wide < bound_single)
        begin
            dec.level = LVL_SINGLE;
            dec.slot  = SLOT_SINGLE;
        end
        else if (idx_wide < bound_double)
        begin
            dec.level = LVL_DOUBLE;
            dec.slot  = SLOT_DOUBLE;
        end
        else if (idx_wide < bound_triple)
        begin
            dec.level = LVL_TRIPLE;
            dec.slot  = SLOT_TRIPLE;
        end
        else
        begin
            dec.level = LVL_RANGE;
            dec.slot  = SLOT_TRIPLE;
        end
    end

endmodule

### rtl/bmiw_walk_ctrl.sv
module bmiw_walk_ctrl #(
    parameter int BLOCK_NUMBER_BITS = bmiw_pkg::BLOCK_NUMBER_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [bmiw_pkg::CMD_BITS-1:0]       command,
    input  logic [bmiw_pkg::SLOT_BITS-1:0]      slot_index,
    input  logic [bmiw_pkg::IDX_BITS-1:0]       logical_index,
    input  logic [bmiw_pkg::IDX_BITS-1:0]       data_word,
    input  logic                                read_ok,
    input  logic [bmiw_pkg::LOG2_BITS-1:0]      log2_ppb,
    input  bmiw_pkg::decode_t                   dec,
    input  logic [BLOCK_NUMBER_BITS-1:0]        ptr_rd_data,
    output logic                                ptr_wr_en,
    output logic [bmiw_pkg::SLOT_BITS-1:0]      ptr_wr_addr,
    output logic [BLOCK_NUMBER_BITS-1:0]        ptr_wr_data,
    output logic                                busy,
    output logic                                result_valid,
    output logic [bmiw_pkg::KIND_BITS-1:0]      result_kind,
    output logic [bmiw_pkg::IDX_BITS-1:0]       block_number,
    output logic [bmiw_pkg::WORD_BITS-1:0]      word_index
);
    import bmiw_pkg::*;

    state_t state_reg, state_next;
    logic   accept;

    // Item held through the evaluate cycle.
    logic [CMD_BITS-1:0]          cmd_reg;
    logic [IDX_BITS-1:0]          idx_reg;
    logic [BLOCK_NUMBER_BITS-1:0] word_reg;
    logic                         ok_reg;
    level_t                       level_reg;
    logic [IDX_BITS-1:0]          base_reg;

    // Walk state.
    logic                  walk_busy_reg, walk_busy_next;
    logic [LEVEL_BITS-1:0] levels_reg, levels_next;
    logic [WORD_BITS-1:0]  second_reg, second_next;
    logic [WORD_BITS-1:0]  third_reg, third_next;

    // Result registers.
    logic                  result_valid_reg, result_valid_next;
    logic [KIND_BITS-1:0]  kind_reg, kind_next;
    logic [IDX_BITS-1:0]   block_reg, block_next;
    logic [WORD_BITS-1:0]  word_idx_reg, word_idx_next;

    // Index split helpers for the evaluate cycle.
    logic [4:0]           shift2;
    logic [WORD_BITS:0]   mask_wide;
    logic [WORD_BITS-1:0] mask;
    logic [IDX_BITS-1:0]  rel;
    logic [WORD_BITS-1:0] rel_lo;
    logic [WORD_BITS-1:0] rel_mid;
    logic [WORD_BITS-1:0] rel_hi;
    logic [IDX_BITS-1:0]  ptr_ext;
    logic [IDX_BITS-1:0]  word_ext;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State outputs and the pointer write of a load item.
    always_comb
    begin
        busy        = (state_reg != ST_IDLE);
        accept      = start && !busy;
        ptr_wr_en   = accept && !walk_busy_reg && (command == CMD_LOAD);
        ptr_wr_addr = slot_index;
        ptr_wr_data = data_word[BLOCK_NUMBER_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Capture the accepted item.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg   <= command;
            idx_reg   <= logical_index;
            word_reg  <= data_word[BLOCK_NUMBER_BITS-1:0];
            ok_reg    <= read_ok;
            level_reg <= dec.level;
            case (dec.level)
                LVL_SINGLE: base_reg <= dec.base_single;
                LVL_DOUBLE: base_reg <= dec.base_double;
                LVL_TRIPLE: base_reg <= dec.base_triple;
                default:    base_reg <= '0;
            endcase
        end
    end

    // Split the offset within the region into per-level word indexes.
    assign shift2    = {1'b0, log2_ppb} << 1;
    assign mask_wide = ((WORD_BITS+1)'(1) << log2_ppb) - (WORD_BITS+1)'(1);
    assign mask      = mask_wide[WORD_BITS-1:0];
    assign rel       = idx_reg - base_reg;
    assign rel_lo    = rel[WORD_BITS-1:0] & mask;
    assign rel_mid   = WORD_BITS'(rel >> log2_ppb) & mask;
    assign rel_hi    = WORD_BITS'(rel >> shift2) & mask;
    assign ptr_ext   = IDX_BITS'(ptr_rd_data);
    assign word_ext  = IDX_BITS'(word_reg);

    // Evaluate the item against the walk state and the pointer read.
    always_comb
    begin
        walk_busy_next    = walk_busy_reg;
        levels_next       = levels_reg;
        second_next       = second_reg;
        third_next        = third_reg;
        result_valid_next = 1'b0;
        kind_next         = kind_reg;
        block_next        = block_reg;
        word_idx_next     = word_idx_reg;
        if (state_reg == ST_EVAL)
        begin
            if (walk_busy_reg)
            begin
                result_valid_next = 1'b1;
                block_next        = '0;
                word_idx_next     = '0;
                if ((cmd_reg == CMD_RESPONSE) && ok_reg && (levels_reg > LEVELS_ONE)
                    && (word_ext != '0))
                begin
                    // Descend one more level.
                    kind_next   = KIND_REQUEST;
                    block_next  = word_ext;
                    word_idx_next = second_reg;
                    second_next = third_reg;
                    levels_next = levels_reg - LEVELS_ONE;
                end
                else
                begin
                    walk_busy_next = 1'b0;
                    levels_next    = '0;
                    if ((cmd_reg == CMD_RESPONSE) && ok_reg)
                    begin
                        kind_next  = KIND_RESOLVED;
                        block_next = word_ext;
                    end
                    else
                    begin
                        kind_next = KIND_ERROR;
                    end
                end
            end
            else if (cmd_reg == CMD_RESOLVE)
            begin
                result_valid_next = 1'b1;
                kind_next         = KIND_RESOLVED;
                block_next        = ptr_ext;
                word_idx_next     = '0;
                case (level_reg)
                    LVL_DIRECT:
                    begin
                        block_next = ptr_ext;
                    end
                    LVL_SINGLE:
                    begin
                        if (ptr_ext != '0)
                        begin
                            kind_next      = KIND_REQUEST;
                            word_idx_next  = rel_lo;
                            walk_busy_next = 1'b1;
                            levels_next    = LEVELS_ONE;
                        end
                    end
                    LVL_DOUBLE:
                    begin
                        if (ptr_ext != '0)
                        begin
                            kind_next      = KIND_REQUEST;
                            word_idx_next  = rel_mid;
                            second_next    = rel_lo;
                            walk_busy_next = 1'b1;
                            levels_next    = LEVELS_TWO;
                        end
                    end
                    LVL_TRIPLE:
                    begin
                        if (ptr_ext != '0)
                        begin
                            kind_next      = KIND_REQUEST;
                            word_idx_next  = rel_hi;
                            second_next    = rel_mid;
                            third_next     = rel_lo;
                            walk_busy_next = 1'b1;
                            levels_next    = LEVELS_THREE;
                        end
                    end
                    default:
                    begin
                        kind_next  = KIND_ERROR;
                        block_next = '0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            walk_busy_reg    <= 1'b0;
            levels_reg       <= '0;
            second_reg       <= '0;
            third_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            walk_busy_reg    <= walk_busy_next;
            levels_reg       <= levels_next;
            second_reg       <= second_next;
            third_reg        <= third_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        kind_reg     <= kind_next;
        block_reg    <= block_next;
        word_idx_reg <= word_idx_next;
    end

    assign result_valid = result_valid_reg;
    assign result_kind  = kind_reg;
    assign block_number = block_reg;
    assign word_index   = word_idx_reg;

endmodule

### rtl/block_map_indirect_walker.sv
// Channel   | Direction | Handshake                 | Payload
// ----------+-----------+---------------------------+----------------------------------------
// item      | in        | start && !busy            | command, slot_index, logical_index,
//           |           |                           | data_word, read_ok
// result    | out       | result_valid, one cycle   | result_kind, block_number, word_index
// config    | in        | cfg_wr_en                 | cfg_wr_data
//
// For every item, the accept edge issues the pointer memory read, and busy is
// high for the one evaluate cycle in which the read data comes back.
// A result, if any, is strobed in the cycle after the evaluate cycle; a new item may be
// accepted in that same cycle, but no new item is taken while busy is high.
// rst_n clears the walk state and marks all fifteen pointer slots as holes at once.
// The receiver cannot stall; each result is shown for exactly one cycle.
module block_map_indirect_walker #(
    parameter int DIRECT_SLOTS      = bmiw_pkg::DIRECT_SLOTS_DEF,
    parameter int BLOCK_NUMBER_BITS = bmiw_pkg::BLOCK_NUMBER_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [bmiw_pkg::CMD_BITS-1:0]      command,
    input  logic [bmiw_pkg::SLOT_BITS-1:0]     slot_index,
    input  logic [bmiw_pkg::IDX_BITS-1:0]      logical_index,
    input  logic [bmiw_pkg::IDX_BITS-1:0]      data_word,
    input  logic                               read_ok,
    output logic                               result_valid,
    output logic [bmiw_pkg::KIND_BITS-1:0]     result_kind,
    output logic [bmiw_pkg::IDX_BITS-1:0]      block_number,
    output logic [bmiw_pkg::WORD_BITS-1:0]     word_index,
    input  logic                               cfg_wr_en,
    input  logic [bmiw_pkg::LOG2_BITS-1:0]     cfg_wr_data
);
    import bmiw_pkg::*;

    logic [LOG2_BITS-1:0]         log2_reg;
    logic [LOG2_BITS-1:0]         log2_ppb;
    decode_t                      dec;
    logic                         ptr_wr_en;
    logic [SLOT_BITS-1:0]         ptr_wr_addr;
    logic [BLOCK_NUMBER_BITS-1:0] ptr_wr_data;
    logic [BLOCK_NUMBER_BITS-1:0] ptr_rd_data;

    // Block size register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            log2_reg <= LOG2_RESET;
        end
        else if (cfg_wr_en)
        begin
            log2_reg <= cfg_wr_data;
        end
    end

    // Out-of-range settings act as the nearest legal block size.
    always_comb
    begin
        if (log2_reg < LOG2_MIN)
        begin
            log2_ppb = LOG2_MIN;
        end
        else if (log2_reg > LOG2_MAX)
        begin
            log2_ppb = LOG2_MAX;
        end
        else
        begin
            log2_ppb = log2_reg;
        end
    end

    bmiw_index_decode #(
        .DIRECT_SLOTS(DIRECT_SLOTS)
    ) u_decode (
        .logical_index(logical_index),
        .log2_ppb     (log2_ppb),
        .dec          (dec)
    );

    bmiw_ptr_mem #(
        .BLOCK_NUMBER_BITS(BLOCK_NUMBER_BITS)
    ) u_ptr_mem (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (ptr_wr_en),
        .wr_addr(ptr_wr_addr),
        .wr_data(ptr_wr_data),
        .rd_addr(dec.slot),
        .rd_data(ptr_rd_data)
    );

    bmiw_walk_ctrl #(
        .BLOCK_NUMBER_BITS(BLOCK_NUMBER_BITS)
    ) u_walk (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .command      (command),
        .slot_index   (slot_index),
        .logical_index(logical_index),
        .data_word    (data_word),
        .read_ok      (read_ok),
        .log2_ppb     (log2_ppb),
        .dec          (dec),
        .ptr_rd_data  (ptr_rd_data),
        .ptr_wr_en    (ptr_wr_en),
        .ptr_wr_addr  (ptr_wr_addr),
        .ptr_wr_data  (ptr_wr_data),
        .busy         (busy),
        .result_valid (result_valid),
        .result_kind  (result_kind),
        .block_number (block_number),
        .word_index   (word_index)
    );

    // An accepted item always enters evaluation in the cycle after it is accepted.
    a_accept_eval: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not enter evaluation");

    // A result only follows an evaluate cycle.
    a_result_after_eval: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> ($past(busy) && !busy))
        else $error("result strobe without a preceding evaluate cycle");

    // Only requests carry a word index.
    a_word_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (result_kind != KIND_REQUEST)) |-> (word_index == '0))
        else $error("non-request result with a nonzero word index");

    // Errors never name a block.
    a_error_block_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (result_kind == KIND_ERROR)) |-> (block_number == '0))
        else $error("error result with a nonzero block number");

endmodule
